// ----- src/moon_illum_pkg.sv -----
// Shared types, constants and table functions for the moon illumination block.
package moon_illum_pkg;

  // Request and result payloads as they appear on the ports.
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } req_t;

  typedef struct packed {
    logic [6:0]  illumination_percent;
    logic [15:0] phase_fraction;
    logic        bad_month;
  } res_t;

  // Magnitude width of the signed half-day difference 2*jdn - 4903101.
  localparam int unsigned MAG_W = 24;

  // One queue entry between the day-number front end and the phase back end.
  typedef struct packed {
    logic             bad;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } q_entry_t;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  // Day-number constants. HALF_REF folds the -32045 offset into the reference.
  localparam logic [14:0] YEAR_BIAS   = 15'd4800;
  localparam logic [22:0] MUL_YEAR    = 23'd365;
  localparam logic [27:0] RECIP_100   = 28'd5243;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam logic [24:0] HALF_REF    = 25'd4967191;

  // Synodic month as a ratio; the fixed-point value is formed per FRAC_BITS.
  localparam logic [63:0] SYN_NUM = 64'd29530588;
  localparam logic [63:0] SYN_DEN = 64'd1000000;

  // Radix-4 steps of the shared remainder unit.
  localparam int unsigned MOD_STEPS = 10;
  localparam int unsigned PH_STEPS  = 8;
  localparam int unsigned CNT_W     = 4;

  // Cosine table generation constants.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [8] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                              64'd90, 64'd132, 64'd182, 64'd240};

  // Month-dependent term (153*m + 2)/5 of the day-number formula, with the
  // year starting in March.
  function automatic logic [8:0] month_offset(input logic [3:0] month);
    logic [8:0] ofs;
    case (month)
      4'd1:    ofs = 9'd306;
      4'd2:    ofs = 9'd337;
      4'd3:    ofs = 9'd0;
      4'd4:    ofs = 9'd31;
      4'd5:    ofs = 9'd61;
      4'd6:    ofs = 9'd92;
      4'd7:    ofs = 9'd122;
      4'd8:    ofs = 9'd153;
      4'd9:    ofs = 9'd184;
      4'd10:   ofs = 9'd214;
      4'd11:   ofs = 9'd245;
      4'd12:   ofs = 9'd275;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

  // Quarter-wave cosine entry in Q16, evaluated at elaboration only.
  function automatic logic [16:0] cos_entry(input int unsigned k, input int unsigned tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    longint      sum;
    x   = (64'(k) * HALF_PI_Q30) >> tbits;
    x2  = (x * x) >> 30;
    t   = 64'd1 << 30;
    sum = longint'(t);
    for (int n = 1; n <= 8; n++) begin
      t = ((t * x2) >> 30) / TAYLOR_DIV[n-1];
      if ((n & 1) != 0) begin
        sum = sum - longint'(t);
      end else begin
        sum = sum + longint'(t);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 64'sd8192) >>> 14;
    if (sum > 65536) begin
      sum = 65536;
    end
    return 17'(sum);
  endfunction

endpackage

// ----- src/moon_illum_front.sv -----
// Front end: checks the month and forms the signed half-day difference.
module moon_illum_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  moon_illum_pkg::req_t       req_i,
  output logic                       push_o,
  output moon_illum_pkg::q_entry_t   entry_o,
  output logic [1:0]                 inflight_o
);

  logic v1_q, v2_q, v3_q;

  // Stage 1: shifted year, month term, day.
  logic        bad1_q, bad1_d;
  logic [14:0] y1_q, y1_d;
  logic [8:0]  mt1_q, mt1_d;
  logic [4:0]  day1_q;

  // Stage 2: products.
  logic        bad2_q;
  logic [22:0] p365_q, p365_d;
  logic [7:0]  c100_q, c100_d;
  logic [12:0] y4_q;
  logic [8:0]  mt2_q;
  logic [4:0]  day2_q;
  logic [27:0] prod100;

  // Stage 3: day number plus 32045.
  logic        bad3_q;
  logic [22:0] s3_q, s3_d;

  logic [24:0] hs, hneg;

  always_comb begin
    logic is_early;
    is_early = (req_i.month <= 4'd2);
    bad1_d   = (req_i.month == 4'd0) || (req_i.month > 4'd12);
    y1_d     = 15'(req_i.year) + moon_illum_pkg::YEAR_BIAS - 15'(is_early);
    mt1_d    = moon_illum_pkg::month_offset(req_i.month);
  end

  assign prod100 = 28'(y1_q) * moon_illum_pkg::RECIP_100;
  assign c100_d  = prod100[moon_illum_pkg::RECIP_SHIFT+7:moon_illum_pkg::RECIP_SHIFT];
  assign p365_d  = 23'(y1_q) * moon_illum_pkg::MUL_YEAR;

  assign s3_d = p365_q + 23'(y4_q) + 23'(c100_q[7:2]) + 23'(mt2_q) + 23'(day2_q)
              - 23'(c100_q);

  assign hs   = {1'b0, s3_q, 1'b0} - moon_illum_pkg::HALF_REF;
  assign hneg = -hs;

  assign push_o        = v3_q;
  assign entry_o.bad   = bad3_q;
  assign entry_o.neg   = hs[24];
  assign entry_o.mag   = hs[24] ? hneg[moon_illum_pkg::MAG_W-1:0]
                                : hs[moon_illum_pkg::MAG_W-1:0];
  assign inflight_o    = 2'(v1_q) + 2'(v2_q) + 2'(v3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      bad1_q <= bad1_d;
      y1_q   <= y1_d;
      mt1_q  <= mt1_d;
      day1_q <= req_i.day;
    end
    bad2_q <= bad1_q;
    p365_q <= p365_d;
    c100_q <= c100_d;
    y4_q   <= y1_q[14:2];
    mt2_q  <= mt1_q;
    day2_q <= day1_q;
    bad3_q <= bad2_q;
    s3_q   <= s3_d;
  end

endmodule

// ----- src/moon_illum_fifo.sv -----
// Short queue that decouples the front end from the back end.
module moon_illum_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  moon_illum_pkg::q_entry_t   entry_i,
  input  logic                       pop_i,
  output moon_illum_pkg::q_entry_t   entry_o,
  output moon_illum_pkg::q_stat_t    stat_o
);

  moon_illum_pkg::q_entry_t mem_q [moon_illum_pkg::QUEUE_DEPTH];

  logic [moon_illum_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [moon_illum_pkg::QCNT_W-1:0] cnt_q;
  logic                              do_pop;

  assign do_pop       = pop_i && (cnt_q != '0);
  assign entry_o      = mem_q[rd_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.count = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

// ----- src/moon_illum_back.sv -----
// Back end: modulo reduction, phase division and cosine lookup.
module moon_illum_back #(
  parameter int unsigned FRAC_BITS      = 24,
  parameter int unsigned COS_TABLE_BITS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  moon_illum_pkg::q_entry_t   entry_i,
  input  moon_illum_pkg::q_stat_t    stat_i,
  output logic                       pop_o,
  output logic                       done_o,
  output moon_illum_pkg::res_t       res_o
);

  localparam int unsigned RW    = FRAC_BITS + 5;
  localparam int unsigned DW    = moon_illum_pkg::MAG_W + FRAC_BITS - 1;
  localparam int unsigned LOW_W = 2 * moon_illum_pkg::MOD_STEPS;
  localparam int unsigned CW    = moon_illum_pkg::CNT_W;
  localparam int unsigned TB    = COS_TABLE_BITS;
  localparam int unsigned IW    = COS_TABLE_BITS + 1;
  localparam int unsigned NENT  = (1 << COS_TABLE_BITS) + 1;

  localparam logic [RW-1:0] SYN_FIX =
    RW'(((moon_illum_pkg::SYN_NUM << FRAC_BITS) + (moon_illum_pkg::SYN_DEN >> 1))
        / moon_illum_pkg::SYN_DEN);
  localparam logic [RW+1:0] SYN1 = (RW+2)'(SYN_FIX);
  localparam logic [RW+1:0] SYN2 = SYN1 << 1;
  localparam logic [RW+1:0] SYN3 = SYN1 + SYN2;
  localparam logic [IW-1:0] N_IDX = IW'(1) << COS_TABLE_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_FIX,
    ST_PHASE,
    ST_LOOK
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          fin_q, fin_d;
  logic          fin_bad_q, fin_bad_d;
  logic          done_q;

  logic [RW-1:0]    r_q, r_d;
  logic [LOW_W-1:0] sh_q, sh_d;
  logic [15:0]      qt_q, qt_d;
  logic             neg_q, neg_d;
  logic [16:0]      t_q, t_d;
  logic             tneg_q, tneg_d;
  logic [15:0]      ph_q, ph_d;
  moon_illum_pkg::res_t res_q;

  logic [DW-1:0] dvd;
  logic [1:0]    dig, q_dig;
  logic [RW+1:0] r4, sub, rem4;
  logic [RW-1:0] r_step;

  logic [16:0]   rnd, idx_full;
  logic [TB+1:0] iq;
  logic [IW-1:0] tidx;

  logic [16:0] cos_rom [NENT];

  for (genvar g = 0; g < NENT; g++) begin : g_cos
    localparam logic [16:0] ENT = moon_illum_pkg::cos_entry(g, COS_TABLE_BITS);
    assign cos_rom[g] = ENT;
  end

  assign dvd = {entry_i.mag, {(FRAC_BITS-1){1'b0}}};

  // One radix-4 restoring step: remainder stays below the synodic month.
  assign dig = (state_q == ST_MOD) ? sh_q[LOW_W-1 -: 2] : 2'b00;
  assign r4  = {r_q, dig};

  always_comb begin
    if (r4 >= SYN3) begin
      q_dig = 2'd3;
      sub   = SYN3;
    end else if (r4 >= SYN2) begin
      q_dig = 2'd2;
      sub   = SYN2;
    end else if (r4 >= SYN1) begin
      q_dig = 2'd1;
      sub   = SYN1;
    end else begin
      q_dig = 2'd0;
      sub   = '0;
    end
  end

  assign rem4   = r4 - sub;
  assign r_step = rem4[RW-1:0];

  // Round the phase to the nearest of four table quadrants' steps.
  assign rnd      = {1'b0, qt_q} + (17'(1) << (13 - COS_TABLE_BITS));
  assign idx_full = rnd >> (14 - COS_TABLE_BITS);
  assign iq       = idx_full[TB+1:0];
  assign tidx     = iq[TB] ? (N_IDX - {1'b0, iq[TB-1:0]}) : {1'b0, iq[TB-1:0]};

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    fin_d     = 1'b0;
    fin_bad_d = fin_bad_q;
    r_d       = r_q;
    sh_d      = sh_q;
    qt_d      = qt_q;
    neg_d     = neg_q;
    t_d       = t_q;
    tneg_d    = tneg_q;
    ph_d      = ph_q;
    pop_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!stat_i.empty) begin
          pop_o = 1'b1;
          if (entry_i.bad) begin
            fin_d     = 1'b1;
            fin_bad_d = 1'b1;
          end else begin
            r_d     = RW'(dvd[DW-1:LOW_W]);
            sh_d    = dvd[LOW_W-1:0];
            neg_d   = entry_i.neg;
            cnt_d   = CW'(moon_illum_pkg::MOD_STEPS - 1);
            state_d = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        r_d  = r_step;
        sh_d = sh_q << 2;
        if (cnt_q == '0) begin
          state_d = ST_FIX;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_FIX: begin
        // A negative difference leaves a negative remainder; fold it into range.
        if (neg_q && (r_q != '0)) begin
          r_d = SYN_FIX - r_q;
        end
        cnt_d   = CW'(moon_illum_pkg::PH_STEPS - 1);
        state_d = ST_PHASE;
      end
      ST_PHASE: begin
        r_d  = r_step;
        qt_d = {qt_q[13:0], q_dig};
        if (cnt_q == '0) begin
          state_d = ST_LOOK;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_LOOK: begin
        t_d       = cos_rom[tidx];
        tneg_d    = iq[TB] ^ iq[TB+1];
        ph_d      = qt_q;
        fin_d     = 1'b1;
        fin_bad_d = 1'b0;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      fin_q     <= 1'b0;
      fin_bad_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      fin_q     <= fin_d;
      fin_bad_q <= fin_bad_d;
      done_q    <= fin_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    sh_q   <= sh_d;
    qt_q   <= qt_d;
    neg_q  <= neg_d;
    t_q    <= t_d;
    tneg_q <= tneg_d;
    ph_q   <= ph_d;
  end

  // Output stage: (1 - cos)/2 as a rounded percent.
  always_ff @(posedge clk_i) begin
    logic [17:0] u;
    logic [23:0] num;
    u   = tneg_q ? (18'd65536 + 18'(t_q)) : (18'd65536 - 18'(t_q));
    num = (24'(u) << 6) + (24'(u) << 5) + (24'(u) << 2) + 24'd65536;
    if (fin_q) begin
      if (fin_bad_q) begin
        res_q.illumination_percent <= '0;
        res_q.phase_fraction       <= '0;
        res_q.bad_month            <= 1'b1;
      end else begin
        res_q.illumination_percent <= num[23:17];
        res_q.phase_fraction       <= ph_q;
        res_q.bad_month            <= 1'b0;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ----- src/moon_illumination_from_date_top.sv -----
// Top level of the moon illumination block: front end, queue and back end.
//
// A request carries a Gregorian date (year, month, day) on req_i and is taken
// at a rising edge where start is high and busy is low. Each request gives
// exactly one result on res_o, shown for one cycle with done_o high; results
// come out in request order. The receiver cannot hold results off, so the
// output register simply hands each result over in the cycle it is ready.
//
// A month outside 1 to 12 reports bad_month with zero fields. For a valid
// month the back end works in order: the radix-4 remainder unit works 10 steps
// to reduce the day difference modulo the synodic month, one state folds
// negative remainders, 8 more steps divide out the 16-bit phase, and a last
// state reads the cosine table. A bad month is finished from the idle state.
// The three-stage front end and a four-entry queue keep taking requests while
// the back end works; busy rises when queued plus in-flight requests fill the
// queue.
// Reset empties the pipeline and the queue; busy and done_o are low after it.
module moon_illumination_from_date_top #(
  parameter int unsigned FRAC_BITS      = 24,
  parameter int unsigned COS_TABLE_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  moon_illum_pkg::req_t   req_i,
  output logic                   done_o,
  output moon_illum_pkg::res_t   res_o
);

  logic                       accept;
  logic                       push;
  logic                       pop;
  logic [1:0]                 inflight;
  moon_illum_pkg::q_entry_t   push_entry;
  moon_illum_pkg::q_entry_t   head_entry;
  moon_illum_pkg::q_stat_t    q_stat;
  logic [moon_illum_pkg::QCNT_W-1:0] occupancy;

  // Requests already in the front pipeline are counted against the queue so
  // that every accepted request is sure of a slot when it arrives.
  assign occupancy = q_stat.count + moon_illum_pkg::QCNT_W'(inflight);
  assign busy      = (occupancy >= moon_illum_pkg::QCNT_W'(moon_illum_pkg::QUEUE_DEPTH));
  assign accept    = start && !busy;

  moon_illum_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_i      (req_i),
    .push_o     (push),
    .entry_o    (push_entry),
    .inflight_o (inflight)
  );

  moon_illum_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .stat_o  (q_stat)
  );

  moon_illum_back #(
    .FRAC_BITS      (FRAC_BITS),
    .COS_TABLE_BITS (COS_TABLE_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (head_entry),
    .stat_i  (q_stat),
    .pop_o   (pop),
    .done_o  (done_o),
    .res_o   (res_o)
  );

endmodule

// ----- src/moon_illum_checker.sv -----
// Port-level checker for the moon illumination block, bound to the top level.
module moon_illum_sva (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start,
  input logic                   busy,
  input logic                   done_o,
  input moon_illum_pkg::res_t   res_o
);

  // A bad month reports zero in both result fields.
  a_bad_month_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.bad_month |->
      (res_o.illumination_percent == 7'd0) && (res_o.phase_fraction == 16'd0))
    else $error("bad month result carries nonzero fields");

  // The illuminated fraction never exceeds a full moon.
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.illumination_percent <= 7'd100))
    else $error("illumination percent above 100");

  // At the start of the synodic month the moon is dark.
  a_new_moon_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.bad_month && (res_o.phase_fraction == 16'd0) |->
      (res_o.illumination_percent == 7'd0))
    else $error("zero phase with nonzero illumination");

  // The back end needs many cycles per valid month, so two such results
  // never come out in adjacent cycles.
  a_valid_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.bad_month |=> !(done_o && !res_o.bad_month))
    else $error("valid results in adjacent cycles");

  // An accepted request is followed by a result within a bounded time.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##[1:200] done_o)
    else $error("no result after an accepted request");

endmodule

bind moon_illumination_from_date_top moon_illum_sva u_checker (.*);

// ----- bench/moon_illum_checker.sv -----
// Checker for the moon illumination block: predicts each request's result and compares it.
module moon_illum_checker #(
  parameter int unsigned FRAC_BITS      = 24,
  parameter int unsigned COS_TABLE_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  moon_illum_pkg::req_t req_i,
  input  logic                 done_i,
  input  moon_illum_pkg::res_t res_i,
  output int                   outstanding_o,
  output int                   errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STEPS     = 1 << COS_TABLE_BITS;
  localparam int unsigned MAX_SHOWN = 10;
  // Synodic month in days, fixed point with FRAC_BITS fraction bits, rounded.
  localparam longint SYNODIC_FIX =
    longint'(((64'd29530588 << FRAC_BITS) + 64'd500000) / 64'd1000000);

  longint               quarter_cos [STEPS+1];
  moon_illum_pkg::res_t moon_due [$];
  moon_illum_pkg::res_t want;
  int                   error_count;
  int                   shown;

  // Quarter-wave cosine in Q16 from a nine-term Taylor series in Q30.
  initial begin
    longint unsigned ang;
    longint unsigned ang2;
    longint unsigned term;
    longint          acc;
    for (int k = 0; k <= STEPS; k++) begin
      ang  = (64'(k) * 64'd1686629713) >> COS_TABLE_BITS;
      ang2 = (ang * ang) >> 30;
      term = 64'd1 << 30;
      acc  = longint'(term);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * ang2) >> 30) / 64'((2 * n - 1) * (2 * n));
        if ((n % 2) == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      acc = (acc + 8192) >> 14;
      if (acc > 65536) begin
        acc = 65536;
      end
      quarter_cos[k] = acc;
    end
  end

  function automatic moon_illum_pkg::res_t moon_for_date(input moon_illum_pkg::req_t d);
    longint early;
    longint yr;
    longint mo;
    longint jdn;
    longint diff;
    longint age;
    longint phase;
    longint idx;
    longint quad;
    longint k;
    longint cosv;
    longint pct;
    moon_illum_pkg::res_t r;
    r = '0;
    if (d.month < 4'd1 || d.month > 4'd12) begin
      r.bad_month = 1'b1;
      return r;
    end
    early = (d.month <= 4'd2) ? 1 : 0;
    yr    = longint'(d.year) + 4800 - early;
    mo    = longint'(d.month) + 12 * early - 3;
    jdn   = longint'(d.day) + (153 * mo + 2) / 5 + 365 * yr + yr / 4 - yr / 100
            + yr / 400 - 32045;
    // Half-day count from the reference new moon, scaled to FRAC_BITS.
    diff  = (2 * jdn - 4903101) * (longint'(1) << (FRAC_BITS - 1));
    age   = diff % SYNODIC_FIX;
    if (age < 0) begin
      age = age + SYNODIC_FIX;
    end
    phase = ((age << 16) / SYNODIC_FIX) & 64'hFFFF;
    idx   = ((phase + (longint'(1) << (13 - COS_TABLE_BITS))) >> (14 - COS_TABLE_BITS))
            & longint'(4 * STEPS - 1);
    quad  = idx >> COS_TABLE_BITS;
    k     = idx & longint'(STEPS - 1);
    case (quad)
      0:       cosv = quarter_cos[k];
      1:       cosv = -quarter_cos[STEPS - k];
      2:       cosv = -quarter_cos[k];
      default: cosv = quarter_cos[STEPS - k];
    endcase
    pct = ((65536 - cosv) * 100 + 65536) >> 17;
    r.illumination_percent = pct[6:0];
    r.phase_fraction       = phase[15:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      moon_due.delete();
      error_count = 0;
      shown = 0;
      outstanding_o <= 0;
      errors_o <= 0;
    end else begin
      if (done_i == 1'b1) begin
        if (moon_due.size() == 0) begin
          error_count++;
          if (shown < MAX_SHOWN) begin
            shown++;
            $display("%0t: result with none expected: pct %0d phase %0d bad %0b",
                     $realtime, res_i.illumination_percent, res_i.phase_fraction,
                     res_i.bad_month);
          end
        end else begin
          want = moon_due.pop_front();
          if (res_i !== want) begin
            error_count++;
            if (shown < MAX_SHOWN) begin
              shown++;
              $display("%0t: mismatch: expected pct %0d phase %0d bad %0b,",
                       $realtime, want.illumination_percent, want.phase_fraction,
                       want.bad_month,
                       " got pct %0d phase %0d bad %0b",
                       res_i.illumination_percent, res_i.phase_fraction,
                       res_i.bad_month);
            end
          end
        end
      end
      if (start_i && !busy_i) begin
        moon_due.push_back(moon_for_date(req_i));
      end
      outstanding_o <= moon_due.size();
      errors_o <= error_count;
    end
  end

endmodule

// ----- bench/tb_moon_illumination_from_date_top.sv -----
// Testbench top for the moon illumination block: clock, reset, date requests and verdict.
module tb_moon_illumination_from_date_top;
  timeunit 1ns;
  timeprecision 1ps;

  // The limit leaves ample room over the slowest correct run while still
  // catching a hung block.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 550;
  // Wait after the last owed result to catch any result that should not be there.
  localparam int DRAIN_CYCLES  = 40;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  moon_illum_pkg::req_t req;
  logic                 done;
  moon_illum_pkg::res_t res;
  int                   outstanding;
  int                   errors;
  int                   burst_left;
  int                   cycle_count;

  moon_illumination_from_date_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done),
    .res_o  (res)
  );

  // The checker sees the same ports as the block, predicts every accepted
  // request and reports how many results are still owed and how many failed.
  moon_illum_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .req_i         (req),
    .done_i        (done),
    .res_i         (res),
    .outstanding_o (outstanding),
    .errors_o      (errors)
  );

  // A 4 ns clock: low half, then high half.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Present one date at the current falling edge and hold it until a rising
  // edge sees busy low, which is where the block takes the request. Busy is
  // read right after the edge, before the block's registers update, so the
  // value seen is the one the block used. After acceptance the sender may
  // pause: requests come in bursts of random length with random gaps, and
  // some bursts run back to back so that stretches without idling occur too.
  task automatic send_date(input moon_illum_pkg::req_t d);
    int gap;
    start <= 1'b1;
    req   <= d;
    forever begin
      @(posedge clk_i);
      if (!busy) begin
        break;
      end
    end
    @(negedge clk_i);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // Watchdog: if the run has not finished within the cycle limit, the block
  // has hung or lost results.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    moon_illum_pkg::req_t directed [$];
    moon_illum_pkg::req_t d;
    int                   sel;
    start      = 1'b0;
    req        = '0;
    rst_ni     = 1'b0;
    burst_left = 1;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed dates. Around the reference epoch: a new moon and a full moon.
    directed.push_back('{year: 14'd2000, month: 4'd1, day: 5'd6});
    directed.push_back('{year: 14'd2000, month: 4'd1, day: 5'd21});
    // Ends of the nominal calendar range, and of the raw field widths.
    directed.push_back('{year: 14'd1, month: 4'd1, day: 5'd1});
    directed.push_back('{year: 14'd9999, month: 4'd12, day: 5'd31});
    directed.push_back('{year: 14'd0, month: 4'd1, day: 5'd0});
    directed.push_back('{year: 14'd16383, month: 4'd12, day: 5'd31});
    // Months outside 1 to 12 must flag and zero the other fields.
    directed.push_back('{year: 14'd16383, month: 4'd15, day: 5'd31});
    directed.push_back('{year: 14'd0, month: 4'd0, day: 5'd0});
    directed.push_back('{year: 14'd2024, month: 4'd13, day: 5'd15});
    directed.push_back('{year: 14'd1999, month: 4'd14, day: 5'd1});
    // Odd days are not checked: day zero and days past the month's end.
    directed.push_back('{year: 14'd2024, month: 4'd3, day: 5'd0});
    directed.push_back('{year: 14'd2023, month: 4'd2, day: 5'd31});
    directed.push_back('{year: 14'd1900, month: 4'd2, day: 5'd29});
    // An early year gives a negative difference to the reference new moon.
    directed.push_back('{year: 14'd1, month: 4'd3, day: 5'd1});
    // Every valid month once, so that each month offset is used.
    for (int m = 1; m <= 12; m++) begin
      d.year  = 14'($urandom_range(1, 9999));
      d.month = 4'(m);
      d.day   = 5'($urandom_range(1, 31));
      directed.push_back(d);
    end
    foreach (directed[i]) begin
      send_date(directed[i]);
    end

    // Random dates: mostly well-formed ones, some using the full field
    // widths, and some with a month out of range.
    repeat (RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 85) begin
        d.year  = 14'($urandom_range(1, 9999));
        d.month = 4'($urandom_range(1, 12));
        d.day   = 5'($urandom_range(1, 31));
      end else if (sel < 93) begin
        d.year  = 14'($urandom_range(0, 16383));
        d.month = 4'($urandom_range(1, 12));
        d.day   = 5'($urandom_range(0, 31));
      end else begin
        d.year  = 14'($urandom_range(0, 16383));
        d.day   = 5'($urandom_range(0, 31));
        sel     = $urandom_range(0, 3);
        d.month = (sel == 0) ? 4'd0 : 4'(12 + sel);
      end
      send_date(d);
    end
    start <= 1'b0;

    // Let every owed result arrive, then give the block time to show any
    // result that should not be there.
    while (outstanding != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (errors == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
